[rtl/amx2d_pkg.sv]
package amx2d_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [3:0] CMD_LOAD      = 4'd0;
  localparam logic [3:0] CMD_PREMUL    = 4'd1;
  localparam logic [3:0] CMD_CONCAT    = 4'd2;
  localparam logic [3:0] CMD_TRANSLATE = 4'd3;
  localparam logic [3:0] CMD_SCALE     = 4'd4;
  localparam logic [3:0] CMD_ROTATE    = 4'd5;
  localparam logic [3:0] CMD_SCALE_ROT = 4'd6;
  localparam logic [3:0] CMD_INVERT    = 4'd7;
  localparam logic [3:0] CMD_IDENTITY  = 4'd8;
  localparam logic [3:0] CMD_VERTEX    = 4'd9;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
    logic signed [31:0] arg_c;
    logic signed [31:0] arg_d;
    logic signed [31:0] arg_tx;
    logic signed [31:0] arg_ty;
    logic [15:0]        angle;
  } amx_in_t;

  typedef struct packed {
    logic signed [31:0] mat_a;
    logic signed [31:0] mat_b;
    logic signed [31:0] mat_c;
    logic signed [31:0] mat_d;
    logic signed [31:0] mat_tx;
    logic signed [31:0] mat_ty;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic               only_translation;
    logic               has_rotation;
    logic               singular;
  } amx_out_t;

  // atan(2^-i), 2^30 per quarter turn
  function automatic logic signed [32:0] atan_lut(input logic [4:0] i);
    logic signed [32:0] v;
    unique case (i)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      5'd20: v = 33'sd652;
      5'd21: v = 33'sd326;
      5'd22: v = 33'sd163;
      5'd23: v = 33'sd81;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/affine_matrix_2d_unit_core.sv]
// Every product term goes through the one 32x32 multiplier.
// Rotate first runs the CORDIC shift-add unit; invert runs a restoring
//   divider for each entry.
// Throughput: one item at a time; a finished result waits in the output register.
// Reset (synchronous, rst_n low): identity matrix, translate-only set, threshold 7.
module affine_matrix_2d_unit_core
  import amx2d_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  amx_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output amx_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam logic signed [31:0] ONE_FX  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] ROUND_C = 34'sd1 <<< (29 - FRAC_BITS);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_CORD   = 12'b000000000010,
    ST_CFIN   = 12'b000000000100,
    ST_MUL1   = 12'b000000001000,
    ST_MUL2   = 12'b000000010000,
    ST_ACC    = 12'b000000100000,
    ST_FIN    = 12'b000001000000,
    ST_NUMSET = 12'b000010000000,
    ST_DIVLD  = 12'b000100000000,
    ST_DIV    = 12'b001000000000,
    ST_DIVF   = 12'b010000000000,
    ST_WB     = 12'b100000000000
  } state_t;

  typedef enum logic [4:0] {
    PS_LIN = 5'b00001,
    PS_TRN = 5'b00010,
    PS_SCL = 5'b00100,
    PS_DET = 5'b01000,
    PS_NUM = 5'b10000
  } pass_t;

  state_t             state_r;
  pass_t              pass_r;
  logic [3:0]         cmd_r;
  logic [15:0]        angle_r;
  logic signed [31:0] n_r   [6];
  logic signed [31:0] cur_r [6];
  logic signed [31:0] nm_r  [6];
  logic               to_r, rot_r, nochg_r, sing_r;
  logic [15:0]        thr_r;
  logic [2:0]         k_r;
  logic [5:0]         cnt_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic signed [31:0] cs_r, sn_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r;
  logic signed [63:0] det_r, num_r;
  logic [63:0]        dvd_r, den_r, quo_r;
  logic [64:0]        rem_r;
  logic               neg_r;
  logic signed [31:0] rx_r, ry_r;
  logic               out_valid_r;
  amx_out_t           out_data_r;

  // operand select
  logic               j;
  logic [1:0]         r_idx;
  logic [2:0]         i_r0, i_r1, i_c0, i_c1, i_t;
  logic signed [31:0] f_a, f_b, s_a, s_b, add_op, mul_a, mul_b;
  logic               sub_op;
  logic signed [63:0] mul_p;

  assign j     = k_r[0];
  assign r_idx = k_r[2:1];
  assign i_r0  = {r_idx, 1'b0};
  assign i_r1  = {r_idx, 1'b1};
  assign i_c0  = {2'b00, j};
  assign i_c1  = {2'b01, j};
  assign i_t   = {2'b10, j};

  always_comb begin
    f_a = '0; f_b = '0; s_a = '0; s_b = '0; add_op = '0; sub_op = 1'b0;
    unique case (pass_r)
      PS_LIN: begin
        if (cmd_r == CMD_PREMUL) begin
          f_a = n_r[i_r0]; f_b = cur_r[i_c0];
          s_a = n_r[i_r1]; s_b = cur_r[i_c1];
          add_op = k_r[2] ? cur_r[i_t] : '0;
        end else if (cmd_r == CMD_CONCAT) begin
          f_a = cur_r[i_r0]; f_b = n_r[i_c0];
          s_a = cur_r[i_r1]; s_b = n_r[i_c1];
          add_op = k_r[2] ? n_r[i_t] : '0;
        end else begin
          f_a = (r_idx == 2'd0) ? cs_r : -sn_r; f_b = cur_r[i_c0];
          s_a = (r_idx == 2'd0) ? sn_r : cs_r;  s_b = cur_r[i_c1];
        end
      end
      PS_TRN: begin
        if (cmd_r == CMD_TRANSLATE && to_r) begin
          f_a = n_r[k_r]; f_b = ONE_FX; add_op = cur_r[k_r];
        end else begin
          f_a = n_r[4]; f_b = cur_r[i_c0];
          s_a = n_r[5]; s_b = cur_r[i_c1];
          add_op = cur_r[i_t];
        end
      end
      PS_SCL: begin
        f_a = nm_r[k_r]; f_b = k_r[1] ? n_r[5] : n_r[4];
      end
      PS_DET: begin
        f_a = cur_r[0]; f_b = cur_r[3]; s_a = cur_r[1]; s_b = cur_r[2]; sub_op = 1'b1;
      end
      PS_NUM: begin
        sub_op = 1'b1;
        if (!j) begin
          f_a = cur_r[2]; f_b = cur_r[5]; s_a = cur_r[3]; s_b = cur_r[4];
        end else begin
          f_a = cur_r[1]; f_b = cur_r[4]; s_a = cur_r[0]; s_b = cur_r[5];
        end
      end
      default: ;
    endcase
  end

  assign mul_a = (state_r == ST_MUL2) ? s_a : f_a;
  assign mul_b = (state_r == ST_MUL2) ? s_b : f_b;
  assign mul_p = mul_a * mul_b;

  // floor to fraction bits, add term, saturate
  logic signed [65:0] shv;
  logic signed [31:0] shv_sat;
  assign shv = (acc_r >>> FRAC_BITS) + 66'(add_op);
  always_comb begin
    if (shv > 66'sd2147483647)       shv_sat = 32'sh7fffffff;
    else if (shv < -66'sd2147483648) shv_sat = 32'sh80000000;
    else                             shv_sat = shv[31:0];
  end

  // CORDIC step
  logic signed [33:0] sx, sy;
  logic signed [32:0] at;
  assign sx = cx_r >>> cnt_r[4:0];
  assign sy = cy_r >>> cnt_r[4:0];
  assign at = atan_lut(cnt_r[4:0]);

  logic signed [33:0] cv, sv;
  always_comb begin
    unique case (angle_r[15:14])
      2'd0: begin cv = cx_r;  sv = cy_r;  end
      2'd1: begin cv = -cy_r; sv = cx_r;  end
      2'd2: begin cv = -cx_r; sv = -cy_r; end
      default: begin cv = cy_r; sv = -cx_r; end
    endcase
  end
  logic signed [33:0] cs_q, sn_q;
  assign cs_q = (cv + ROUND_C) >>> (30 - FRAC_BITS);
  assign sn_q = (sv + ROUND_C) >>> (30 - FRAC_BITS);

  // divider step
  logic [64:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem_r[63:0], dvd_r[63]};
  assign ge     = rem_sh >= {1'b0, den_r};

  logic signed [63:0] absn, absd;
  assign absn = num_r[63] ? -num_r : num_r;
  assign absd = det_r[63] ? -det_r : det_r;

  logic signed [31:0] div_q;
  always_comb begin
    if (neg_r) div_q = (quo_r > 64'h80000000) ? 32'sh80000000 : -$signed(quo_r[31:0]);
    else       div_q = (quo_r > 64'h7fffffff) ? 32'sh7fffffff : $signed(quo_r[31:0]);
  end

  logic signed [63:0] num_direct;
  always_comb begin
    unique case (k_r[1:0])
      2'd0: num_direct = 64'(cur_r[3]);
      2'd1: num_direct = -64'(cur_r[1]);
      2'd2: num_direct = -64'(cur_r[2]);
      default: num_direct = 64'(cur_r[0]);
    endcase
  end

  // flags at write-back
  logic               ident;
  logic signed [32:0] absb, absc, thr33;
  logic               to_new, rot_new;
  assign ident = nm_r[0] == ONE_FX && nm_r[1] == '0 && nm_r[2] == '0 && nm_r[3] == ONE_FX;
  assign absb  = nm_r[1][31] ? -33'(nm_r[1]) : 33'(nm_r[1]);
  assign absc  = nm_r[2][31] ? -33'(nm_r[2]) : 33'(nm_r[2]);
  assign thr33 = $signed({17'b0, thr_r});

  always_comb begin
    to_new  = to_r;
    rot_new = rot_r;
    unique case (cmd_r)
      CMD_LOAD, CMD_CONCAT: begin
        to_new  = ident;
        rot_new = !ident && (absb > thr33 || absc > thr33);
      end
      CMD_PREMUL: begin to_new = 1'b0; rot_new = 1'b1; end
      CMD_SCALE: if (!nochg_r) to_new = 1'b0;
      CMD_ROTATE: if (!nochg_r) begin to_new = 1'b0; rot_new = 1'b1; end
      CMD_SCALE_ROT: if (!nochg_r) begin to_new = 1'b0; rot_new = angle_r != '0; end
      CMD_INVERT: if (!sing_r) to_new = 1'b0;
      CMD_IDENTITY: begin to_new = 1'b1; rot_new = 1'b0; end
      default: ;
    endcase
  end

  logic in_fire, ones, last_lin, idle_nochg;
  assign in_fire  = in_valid && in_ready;
  assign ones     = in_data.arg_tx == ONE_FX && in_data.arg_ty == ONE_FX;
  assign last_lin = (cmd_r == CMD_PREMUL || cmd_r == CMD_CONCAT) ? (k_r == 3'd5)
                                                                  : (k_r == 3'd3);
  assign idle_nochg = (in_data.command == CMD_SCALE && ones) ||
                      (in_data.command == CMD_ROTATE && in_data.angle == '0) ||
                      (in_data.command == CMD_SCALE_ROT && in_data.angle == '0 && ones);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= PS_LIN;
      out_valid_r <= 1'b0;
      to_r        <= 1'b1;
      rot_r       <= 1'b0;
      thr_r       <= 16'd7;
      cur_r[0]    <= ONE_FX; cur_r[1] <= '0; cur_r[2] <= '0;
      cur_r[3]    <= ONE_FX; cur_r[4] <= '0; cur_r[5] <= '0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (out_valid_r && out_ready && state_r != ST_WB) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: if (in_fire) begin
          cmd_r   <= in_data.command;
          angle_r <= in_data.angle;
          n_r[0] <= in_data.arg_a;  n_r[1] <= in_data.arg_b;
          n_r[2] <= in_data.arg_c;  n_r[3] <= in_data.arg_d;
          n_r[4] <= in_data.arg_tx; n_r[5] <= in_data.arg_ty;
          if (in_data.command != CMD_LOAD && in_data.command != CMD_IDENTITY)
            for (int i = 0; i < 6; i++) nm_r[i] <= cur_r[i];
          rx_r <= '0; ry_r <= '0; sing_r <= 1'b0; nochg_r <= idle_nochg;
          k_r <= (in_data.command == CMD_TRANSLATE || in_data.command == CMD_VERTEX) ?
                 3'd4 : 3'd0;
          cnt_r <= '0;
          cx_r <= CORDIC_GAIN; cy_r <= '0;
          cz_r <= $signed({3'b000, in_data.angle[13:0], 16'b0});
          unique case (in_data.command)
            CMD_LOAD: begin
              nm_r[0] <= in_data.arg_a;  nm_r[1] <= in_data.arg_b;
              nm_r[2] <= in_data.arg_c;  nm_r[3] <= in_data.arg_d;
              nm_r[4] <= in_data.arg_tx; nm_r[5] <= in_data.arg_ty;
              state_r <= ST_WB;
            end
            CMD_IDENTITY: begin
              nm_r[0] <= ONE_FX; nm_r[1] <= '0; nm_r[2] <= '0;
              nm_r[3] <= ONE_FX; nm_r[4] <= '0; nm_r[5] <= '0;
              state_r <= ST_WB;
            end
            CMD_PREMUL, CMD_CONCAT: begin pass_r <= PS_LIN; state_r <= ST_MUL1; end
            CMD_TRANSLATE, CMD_VERTEX: begin
              pass_r <= PS_TRN; state_r <= ST_MUL1;
            end
            CMD_SCALE: begin
              if (ones) state_r <= ST_WB;
              else begin pass_r <= PS_SCL; state_r <= ST_MUL1; end
            end
            CMD_ROTATE: begin
              if (in_data.angle == '0) state_r <= ST_WB;
              else state_r <= ST_CORD;
            end
            CMD_SCALE_ROT: begin
              if (in_data.angle == '0 && ones) state_r <= ST_WB;
              else if (in_data.angle != '0) state_r <= ST_CORD;
              else begin pass_r <= PS_SCL; state_r <= ST_MUL1; end
            end
            CMD_INVERT: begin pass_r <= PS_DET; state_r <= ST_MUL1; end
            default: state_r <= ST_WB;
          endcase
        end
        ST_CORD: begin
          if (!cz_r[32]) begin
            cx_r <= cx_r - sy; cy_r <= cy_r + sx; cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + sy; cy_r <= cy_r - sx; cz_r <= cz_r + at;
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(CORDIC_STEPS - 1)) state_r <= ST_CFIN;
        end
        ST_CFIN: begin
          cs_r <= cs_q[31:0]; sn_r <= sn_q[31:0];
          pass_r <= PS_LIN; k_r <= 3'd0; state_r <= ST_MUL1;
        end
        ST_MUL1: begin prod_r <= mul_p; state_r <= ST_MUL2; end
        ST_MUL2: begin acc_r <= 66'(prod_r); prod_r <= mul_p; state_r <= ST_ACC; end
        ST_ACC: begin
          acc_r   <= sub_op ? acc_r - 66'(prod_r) : acc_r + 66'(prod_r);
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          unique case (pass_r)
            PS_DET: begin
              det_r <= shv[63:0];
              if (shv == '0) begin sing_r <= 1'b1; state_r <= ST_WB; end
              else begin pass_r <= PS_NUM; k_r <= 3'd0; state_r <= ST_NUMSET; end
            end
            PS_NUM: begin num_r <= shv[63:0]; state_r <= ST_DIVLD; end
            PS_TRN: begin
              if (cmd_r == CMD_VERTEX) begin
                if (j) ry_r <= shv_sat; else rx_r <= shv_sat;
              end else nm_r[k_r] <= shv_sat;
              if (k_r == 3'd5) state_r <= ST_WB;
              else begin k_r <= k_r + 3'd1; state_r <= ST_MUL1; end
            end
            PS_LIN: begin
              nm_r[k_r] <= shv_sat;
              if (last_lin) begin
                if (cmd_r == CMD_SCALE_ROT) begin
                  pass_r <= PS_SCL; k_r <= 3'd0; state_r <= ST_MUL1;
                end else state_r <= ST_WB;
              end else begin k_r <= k_r + 3'd1; state_r <= ST_MUL1; end
            end
            default: begin
              nm_r[k_r] <= shv_sat;
              if (k_r == 3'd3) state_r <= ST_WB;
              else begin k_r <= k_r + 3'd1; state_r <= ST_MUL1; end
            end
          endcase
        end
        ST_NUMSET: begin
          if (!k_r[2]) begin num_r <= num_direct; state_r <= ST_DIVLD; end
          else state_r <= ST_MUL1;
        end
        ST_DIVLD: begin
          dvd_r <= 64'(absn) << FRAC_BITS;
          den_r <= absd;
          neg_r <= num_r[63] ^ det_r[63];
          rem_r <= '0; quo_r <= '0; cnt_r <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
          quo_r <= {quo_r[62:0], ge};
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_r <= ST_DIVF;
        end
        ST_DIVF: begin
          nm_r[k_r] <= div_q;
          if (k_r == 3'd5) state_r <= ST_WB;
          else begin k_r <= k_r + 3'd1; state_r <= ST_NUMSET; end
        end
        ST_WB: if (!out_valid_r || out_ready) begin
          for (int i = 0; i < 6; i++) cur_r[i] <= nm_r[i];
          to_r  <= to_new;
          rot_r <= rot_new;
          out_data_r.mat_a  <= nm_r[0]; out_data_r.mat_b  <= nm_r[1];
          out_data_r.mat_c  <= nm_r[2]; out_data_r.mat_d  <= nm_r[3];
          out_data_r.mat_tx <= nm_r[4]; out_data_r.mat_ty <= nm_r[5];
          out_data_r.result_x <= rx_r;
          out_data_r.result_y <= ry_r;
          out_data_r.only_translation <= to_new;
          out_data_r.has_rotation     <= rot_new;
          out_data_r.singular         <= sing_r;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready) else $error("second item taken while busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVLD) |-> (det_r != '0)) else $error("divide by zero determinant");

  a_cordic_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORD) |-> (cnt_r < 6'(CORDIC_STEPS))) else $error("cordic overrun");

  a_wb_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && out_valid_r && !out_ready) |=> (state_r == ST_WB))
    else $error("result dropped while output busy");

endmodule
